FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/imm_pkg.sv
// shared types, constants and the helper function of the matrix multiplier
package imm_pkg;

  // parameter defaults
  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // configuration register layout
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd2;
  localparam logic [CFG_W-1:0]     DIM_RESET     = 4'd8;

  // field widths
  localparam int VALUE_W = 32;

  // input transaction
  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  // result transaction
  typedef struct packed {
    logic signed [VALUE_W-1:0] product;
    logic                      last;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd_en;
    logic first_k;
    logic last_k;
    logic last_entry;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic b_last_slot;
  } status_t;

  // zero reads as one, anything above the maximum reads as the maximum
  function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] d,
                                                 logic [CFG_W-1:0] max_d);
    logic [CFG_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = 4'd1;
    end else if (d > max_d) begin
      r = max_d;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/integer_matrix_multiply_top.sv
// top level of the integer matrix multiplier
// Usage:
//   Load transactions: start with item.mode = 0 for an element of A, 1 for B, each
//   in row-major order. A transaction is taken when start is high and busy low.
//   Dimensions come from the write port (cfg_we, cfg_index, cfg_data): index 0
//   num_rows, 1 inner_dim, 2 num_cols. A write to one of them restarts loading.
//   The transaction that carries the last element of B starts the product: busy
//   rises and one shared multiply-accumulate walks the inner products, one
//   multiply-add per cycle out of the two stores. Entries come out row-major;
//   result.last marks the final entry, which is on result in the cycle where
//   busy falls. Each entry is on result for one cycle with result_valid high;
//   the receiver cannot stall, so no backpressure exists.
//   Reset (rst, synchronous) sets every dimension to 8 and empties both fill
//   counts; stored elements are kept and must be loaded before use.
module integer_matrix_multiply_top
  import imm_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 result_valid,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  cmd_t              cmd;
  status_t           status;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;
  logic [DIM_W-1:0]  rows, inner, cols;

  // controller
  imm_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mode     (item.mode),
    .status   (status),
    .rows     (rows),
    .inner    (inner),
    .cols     (cols),
    .busy     (busy),
    .cmd      (cmd),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b)
  );

  // datapath
  imm_datapath #(
    .MAX_DIM   (MAX_DIM),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .item        (item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .rows        (rows),
    .inner       (inner),
    .cols        (cols),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

FILE: hw/rtl/imm_ctrl.sv
// controller: load handshake and the i/j/k walk over the product
module imm_ctrl
  import imm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        mode,
  input  status_t                     status,
  input  logic [$clog2(MAX_DIM+1)-1:0] rows,
  input  logic [$clog2(MAX_DIM+1)-1:0] inner,
  input  logic [$clog2(MAX_DIM+1)-1:0] cols,
  output logic                        busy,
  output cmd_t                        cmd,
  output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
  output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COMPUTE = 4'b0010,
    ST_DRAIN1  = 4'b0100,
    ST_DRAIN2  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [IDX_W-1:0] i_idx, i_idx_next;
  logic [IDX_W-1:0] j_idx, j_idx_next;
  logic [IDX_W-1:0] k_idx, k_idx_next;
  logic accept;
  logic i_end, j_end, k_end;
  logic [2*DIM_W-1:0] a_lin, b_lin;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // loop end flags
  assign i_end = (DIM_W'(i_idx) == rows  - 1'b1);
  assign j_end = (DIM_W'(j_idx) == cols  - 1'b1);
  assign k_end = (DIM_W'(k_idx) == inner - 1'b1);

  // row-major addresses of a[i][k] and b[k][j]
  assign a_lin     = DIM_W'(i_idx) * inner + DIM_W'(k_idx);
  assign b_lin     = DIM_W'(k_idx) * cols  + DIM_W'(j_idx);
  assign rd_addr_a = a_lin[AW-1:0];
  assign rd_addr_b = b_lin[AW-1:0];

  // next state and commands
  always_comb begin
    state_next     = state;
    i_idx_next     = i_idx;
    j_idx_next     = j_idx;
    k_idx_next     = k_idx;
    cmd.wr_a       = accept && !mode;
    cmd.wr_b       = accept && mode;
    cmd.rd_en      = 1'b0;
    cmd.first_k    = (k_idx == '0);
    cmd.last_k     = k_end;
    cmd.last_entry = k_end && j_end && i_end;
    case (state)
      ST_IDLE: begin
        if (accept && mode && status.b_last_slot) begin
          state_next = ST_COMPUTE;
          i_idx_next = '0;
          j_idx_next = '0;
          k_idx_next = '0;
        end
      end
      ST_COMPUTE: begin
        cmd.rd_en = 1'b1;
        if (k_end) begin
          k_idx_next = '0;
          if (j_end) begin
            j_idx_next = '0;
            if (i_end) begin
              state_next = ST_DRAIN1;
            end else begin
              i_idx_next = i_idx + 1'b1;
            end
          end else begin
            j_idx_next = j_idx + 1'b1;
          end
        end else begin
          k_idx_next = k_idx + 1'b1;
        end
      end
      ST_DRAIN1: begin
        state_next = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_idx <= '0;
      j_idx <= '0;
      k_idx <= '0;
    end else begin
      state <= state_next;
      i_idx <= i_idx_next;
      j_idx <= j_idx_next;
      k_idx <= k_idx_next;
    end
  end

endmodule

FILE: hw/rtl/imm_datapath.sv
// datapath: config registers, element stores, fill counters, multiply-accumulate
module imm_datapath
  import imm_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        cmd,
  input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
  input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b,
  input  item_t                       item,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  output status_t                     status,
  output logic [$clog2(MAX_DIM+1)-1:0] rows,
  output logic [$clog2(MAX_DIM+1)-1:0] inner,
  output logic [$clog2(MAX_DIM+1)-1:0] cols,
  output logic                        result_valid,
  output result_t                     result
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  // low product bits depend only on as many low operand bits
  localparam int ELEM_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic [CFG_W-1:0] num_rows, inner_dim, num_cols;
  logic [CFG_W-1:0] rows_full, inner_full, cols_full;
  logic [2*DIM_W-1:0] size_a_full, size_b_full;
  logic [CW-1:0] size_a, size_b;
  logic [CW-1:0] count_a, count_b;
  logic [CW-1:0] slot_a, slot_b;
  logic cfg_hit;

  logic [ELEM_W-1:0] store_a [DEPTH];
  logic [ELEM_W-1:0] store_b [DEPTH];
  logic [ELEM_W-1:0] a_q, b_q, prod_q, acc;
  logic signed [ELEM_W-1:0] sum;
  logic s1_valid, s1_first, s1_last, s1_end;
  logic s2_valid, s2_first, s2_last, s2_end;

  // clamped dimensions
  assign rows_full  = clamp_dim(num_rows,  CFG_W'(MAX_DIM));
  assign inner_full = clamp_dim(inner_dim, CFG_W'(MAX_DIM));
  assign cols_full  = clamp_dim(num_cols,  CFG_W'(MAX_DIM));
  assign rows  = rows_full[DIM_W-1:0];
  assign inner = inner_full[DIM_W-1:0];
  assign cols  = cols_full[DIM_W-1:0];

  // matrix sizes and write slots, a full store wraps to slot zero
  assign size_a_full = rows  * inner;
  assign size_b_full = inner * cols;
  assign size_a = size_a_full[CW-1:0];
  assign size_b = size_b_full[CW-1:0];
  assign slot_a = (count_a >= size_a) ? '0 : count_a;
  assign slot_b = (count_b >= size_b) ? '0 : count_b;
  assign status.b_last_slot = (slot_b + 1'b1 == size_b);

  assign cfg_hit = cfg_we && ((cfg_index == REG_NUM_ROWS) ||
                              (cfg_index == REG_INNER_DIM) ||
                              (cfg_index == REG_NUM_COLS));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= DIM_RESET;
      inner_dim <= DIM_RESET;
      num_cols  <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ROWS:  num_rows  <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_NUM_COLS:  num_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  // fill counters, cleared by reset, a config write or the write that starts a product
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.wr_a) begin
      count_a <= slot_a + 1'b1;
    end else if (cmd.wr_b) begin
      if (status.b_last_slot) begin
        count_a <= '0;
        count_b <= '0;
      end else begin
        count_b <= slot_b + 1'b1;
      end
    end
  end

  // element store a
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      store_a[slot_a[AW-1:0]] <= item.value[ELEM_W-1:0];
    end
    if (cmd.rd_en) begin
      a_q <= store_a[rd_addr_a];
    end
  end

  // element store b
  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      store_b[slot_b[AW-1:0]] <= item.value[ELEM_W-1:0];
    end
    if (cmd.rd_en) begin
      b_q <= store_b[rd_addr_b];
    end
  end

  // pipeline control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
    end
    s1_first <= cmd.first_k;
    s1_last  <= cmd.last_k;
    s1_end   <= cmd.last_entry;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_end   <= s1_end;
  end

  // multiply stage, low bits only
  always_ff @(posedge clk) begin
    prod_q <= ELEM_W'(a_q * b_q);
  end

  // accumulate stage
  assign sum = s2_first ? prod_q : acc + prod_q;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= sum;
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s2_valid && s2_last;
    end
    result.product <= VALUE_W'(sum);
    result.last    <= s2_end;
  end

endmodule

FILE: hw/rtl/imm_checker.sv
// port-level checker of the matrix multiplier and its bind
`include "assert_macros.svh"

module imm_checker
  import imm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 result_valid,
  input result_t              result
);

  // busy only rises after an accepted transaction
  `ASSERT_IMP(a_busy_from_accept, clk, rst, $rose(busy), $past(start && !busy))

  // every result comes out of a compute pass
  `ASSERT_IMP(a_result_after_busy, clk, rst, result_valid, $past(busy))

  // more entries pending keeps the block busy
  `ASSERT_IMP(a_busy_until_last, clk, rst, result_valid && !result.last, busy)

  // nothing follows the final entry
  `ASSERT_NXT(a_quiet_after_last, clk, rst, result_valid && result.last, !result_valid)

endmodule

bind integer_matrix_multiply_top imm_checker u_imm_checker (.*);
